/* rtl/core/msthm_pkg.sv */
// Shared types and constants of the maximum spanning tree block.
// Depends on nothing; every module of the block imports it.
package msthm_pkg;

  localparam int unsigned IDX_BITS      = 5;
  localparam int unsigned CNT_BITS      = 6;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned IN_DATA_BITS  = 48;
  localparam int unsigned OUT_DATA_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_RESET = 6'd32;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_BUILD = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PAIR = 2'd1,
    ST_NO_TREE  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic build_init;
    logic upd_rd;
    logic upd_wr;
    logic sel_clear;
    logic sel_rd;
    logic sel_chk;
    logic add;
    logic row_rd;
    logic row_lt;
    logic scan_rd;
    logic next_h;
    logic next_row;
    logic emit_edge;
    logic emit_fail;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_build;
    logic v_last;
    logic best_found;
    logic round_last;
    logic n_one;
    logic hit;
    logic h_last;
    logic l_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/msthm_ctrl.sv */
// Sequencer of the maximum spanning tree block: clearing pass, tree growth,
// sorted edge scan. Depends on msthm_pkg; drives the datapath by commands.
module msthm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  msthm_pkg::sts_t sts_i,
  output msthm_pkg::cmd_t cmd_o
);
  import msthm_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_INIT     = 13'b0000000000100,
    S_UPD_RD   = 13'b0000000001000,
    S_UPD_WR   = 13'b0000000010000,
    S_SEL_RD   = 13'b0000000100000,
    S_SEL_CHK  = 13'b0000001000000,
    S_ADD      = 13'b0000010000000,
    S_FAIL     = 13'b0000100000000,
    S_ROW_RD   = 13'b0001000000000,
    S_ROW_LT   = 13'b0010000000000,
    S_SCAN_RD  = 13'b0100000000000,
    S_SCAN_CHK = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == S_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = s_axis_tvalid && s_axis_tready;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_o.accept && sts_i.in_build) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.build_init = 1'b1;
        state_d = sts_i.n_one ? S_IDLE : S_UPD_RD;
      end
      S_UPD_RD: begin
        cmd_o.upd_rd = 1'b1;
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        if (sts_i.v_last) begin
          cmd_o.sel_clear = 1'b1;
          state_d = S_SEL_RD;
        end else begin
          state_d = S_UPD_RD;
        end
      end
      S_SEL_RD: begin
        cmd_o.sel_rd = 1'b1;
        state_d = S_SEL_CHK;
      end
      S_SEL_CHK: begin
        cmd_o.sel_chk = 1'b1;
        state_d = sts_i.v_last ? S_ADD : S_SEL_RD;
      end
      S_ADD: begin
        if (!sts_i.best_found) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.add = 1'b1;
          state_d = sts_i.round_last ? S_ROW_RD : S_UPD_RD;
        end
      end
      S_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fail = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ROW_RD: begin
        cmd_o.row_rd = 1'b1;
        state_d = S_ROW_LT;
      end
      S_ROW_LT: begin
        cmd_o.row_lt = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // Hold here while a tree edge waits for room in the output register.
        if (!(sts_i.hit && !sts_i.out_free)) begin
          cmd_o.emit_edge = sts_i.hit;
          if (sts_i.h_last) begin
            if (sts_i.l_last) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.next_row = 1'b1;
              state_d = S_ROW_RD;
            end
          end else begin
            cmd_o.next_h = 1'b1;
            state_d = S_SCAN_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/msthm_dp.sv */
// Datapath of the maximum spanning tree block: pair score memory, per-item
// key memory, counters, best-key search and output register. Uses msthm_pkg.
module msthm_dp #(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned SCORE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msthm_pkg::cmd_t                     cmd_i,
  output msthm_pkg::sts_t                     sts_o,
  input  logic                                mode_i,
  input  logic [msthm_pkg::IDX_BITS-1:0]      row_i,
  input  logic [msthm_pkg::IDX_BITS-1:0]      col_i,
  input  logic signed [31:0]                  score_i,
  input  logic                                cfg_valid_i,
  input  logic [msthm_pkg::CNT_BITS-1:0]      cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [msthm_pkg::IDX_BITS-1:0]      out_low_o,
  output logic [msthm_pkg::IDX_BITS-1:0]      out_high_o,
  output logic                                out_last_o,
  output msthm_pkg::status_e                  out_status_o
);
  import msthm_pkg::*;

  localparam int unsigned TRI = MAX_ITEMS * (MAX_ITEMS - 1) / 2;
  localparam int unsigned TW  = (TRI > 1) ? $clog2(TRI) : 1;
  localparam int unsigned VW  = $clog2(MAX_ITEMS);
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SB  = SCORE_BITS;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  function automatic logic [TW-1:0] tri_of(input logic [VW-1:0] hi, input logic [VW-1:0] lo);
    logic [2*VW-1:0] prod;
    prod = (2*VW)'(hi) * ((2*VW)'(hi) - (2*VW)'(1));
    return TW'((prod >> 1) + (2*VW)'(lo));
  endfunction

  // Memories.
  logic              pair_vld_mem   [TRI];
  logic signed [SB-1:0] pair_score_mem [TRI];
  logic signed [SB-1:0] key_score_mem  [MAX_ITEMS];
  logic [TW-1:0]     key_tri_mem    [MAX_ITEMS];
  logic [VW-1:0]     key_par_mem    [MAX_ITEMS];
  logic              prd_vld_q;
  logic signed [SB-1:0] prd_score_q, krd_score_q;
  logic [TW-1:0]     krd_tri_q;
  logic [VW-1:0]     krd_par_q;

  // Control registers.
  logic [CNT_BITS-1:0] item_count_q;
  logic [TW-1:0]       clr_q;
  logic [VW-1:0]       v_q, u_q, round_q, l_q, h_q, ecnt_q, best_v_q;
  logic                best_found_q;
  logic [MAX_ITEMS-1:0] in_tree_q, has_q;
  logic                out_valid_q;

  // Payload registers.
  logic signed [SB-1:0] best_score_q;
  logic [TW-1:0]       best_tri_q;
  logic [VW-1:0]       parl_q;
  logic [IDX_BITS-1:0] out_low_q, out_high_q;
  logic                out_last_q;
  status_e             out_status_q;

  logic [CW-1:0]  n, nm1, nm2;
  logic [VW-1:0]  row_v, col_v, lo_uv, hi_uv, key_ra;
  logic [TW-1:0]  tri_uv, pair_wa;
  logic           store_ok, store_acc, err_store, pair_we, key_re, key_we;
  logic           upd_take, sel_take, out_free, out_load;
  logic signed [63:0] s64;
  logic signed [SB-1:0] s_sat;

  always_comb begin
    if (item_count_q == '0) n = CW'(1);
    else if ({1'b0, item_count_q} > 7'(MAX_ITEMS)) n = CW'(MAX_ITEMS);
    else n = CW'(item_count_q);
  end
  assign nm1 = n - CW'(1);
  assign nm2 = n - CW'(2);

  // Store path.
  assign row_v     = VW'(row_i);
  assign col_v     = VW'(col_i);
  assign store_ok  = (row_i > col_i) && (7'(row_i) < 7'(n)) && (7'(col_i) < 7'(n));
  assign store_acc = cmd_i.accept && (mode_i == MODE_STORE);
  assign err_store = store_acc && !store_ok;
  assign s64       = 64'(score_i);
  always_comb begin
    if (s64 > SMAX) s_sat = SB'(SMAX);
    else if (s64 < SMIN) s_sat = SB'(SMIN);
    else s_sat = SB'(s64);
  end
  assign pair_we = cmd_i.clr_step || (store_acc && store_ok);
  assign pair_wa = cmd_i.clr_step ? clr_q : tri_of(row_v, col_v);

  // Edge between the newest tree item and the item under the counter.
  assign lo_uv  = (u_q < v_q) ? u_q : v_q;
  assign hi_uv  = (u_q < v_q) ? v_q : u_q;
  assign tri_uv = tri_of(hi_uv, lo_uv);

  assign upd_take = prd_vld_q && !in_tree_q[v_q] &&
                    (!has_q[v_q] || (prd_score_q > krd_score_q) ||
                     ((prd_score_q == krd_score_q) && (tri_uv < krd_tri_q)));
  assign sel_take = !in_tree_q[v_q] && has_q[v_q] &&
                    (!best_found_q || (krd_score_q > best_score_q) ||
                     ((krd_score_q == best_score_q) && (krd_tri_q < best_tri_q)));
  assign key_we = cmd_i.upd_wr && upd_take;
  assign key_re = cmd_i.upd_rd || cmd_i.sel_rd || cmd_i.row_rd || cmd_i.scan_rd;
  assign key_ra = cmd_i.row_rd ? l_q : (cmd_i.scan_rd ? h_q : v_q);

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_vld_mem[pair_wa]   <= !cmd_i.clr_step;
      pair_score_mem[pair_wa] <= s_sat;
    end
    if (cmd_i.upd_rd) begin
      prd_vld_q   <= pair_vld_mem[tri_uv];
      prd_score_q <= pair_score_mem[tri_uv];
    end
    if (key_we) begin
      key_score_mem[v_q] <= prd_score_q;
      key_tri_mem[v_q]   <= tri_uv;
      key_par_mem[v_q]   <= u_q;
    end
    if (key_re) begin
      krd_score_q <= key_score_mem[key_ra];
      krd_tri_q   <= key_tri_mem[key_ra];
      krd_par_q   <= key_par_mem[key_ra];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = err_store || cmd_i.emit_edge || cmd_i.emit_fail;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_chk && sel_take) begin
      best_score_q <= krd_score_q;
      best_tri_q   <= krd_tri_q;
    end
    if (cmd_i.row_lt) parl_q <= krd_par_q;
    if (out_load) begin
      out_low_q    <= cmd_i.emit_edge ? IDX_BITS'(l_q) : '0;
      out_high_q   <= cmd_i.emit_edge ? IDX_BITS'(h_q) : '0;
      out_last_q   <= cmd_i.emit_edge ? (CW'(ecnt_q) == nm2) : 1'b1;
      out_status_q <= cmd_i.emit_edge ? ST_OK : (err_store ? ST_BAD_PAIR : ST_NO_TREE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= CNT_RESET;
      clr_q        <= '0;
      v_q          <= '0;
      u_q          <= '0;
      round_q      <= '0;
      l_q          <= '0;
      h_q          <= '0;
      ecnt_q       <= '0;
      best_v_q     <= '0;
      best_found_q <= 1'b0;
      in_tree_q    <= '0;
      has_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) item_count_q <= cfg_data_i;
      if (cmd_i.clr_step) clr_q <= clr_q + TW'(1);
      if (cmd_i.build_init) begin
        in_tree_q    <= MAX_ITEMS'(1);
        has_q        <= '0;
        u_q          <= '0;
        v_q          <= '0;
        round_q      <= '0;
        l_q          <= '0;
        ecnt_q       <= '0;
      end
      if (cmd_i.upd_wr || cmd_i.sel_chk) v_q <= sts_o.v_last ? '0 : v_q + VW'(1);
      if (key_we) has_q[v_q] <= 1'b1;
      if (cmd_i.sel_clear) best_found_q <= 1'b0;
      if (cmd_i.sel_chk && sel_take) begin
        best_found_q <= 1'b1;
        best_v_q     <= v_q;
      end
      if (cmd_i.add) begin
        in_tree_q[best_v_q] <= 1'b1;
        u_q     <= best_v_q;
        round_q <= round_q + VW'(1);
      end
      if (cmd_i.row_rd) h_q <= l_q + VW'(1);
      if (cmd_i.next_h) h_q <= h_q + VW'(1);
      if (cmd_i.next_row) l_q <= l_q + VW'(1);
      if (cmd_i.emit_edge) ecnt_q <= ecnt_q + VW'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (32'(clr_q) == TRI - 1);
    sts_o.in_build   = (mode_i == MODE_BUILD);
    sts_o.v_last     = (CW'(v_q) == nm1);
    sts_o.best_found = best_found_q;
    sts_o.round_last = (CW'(round_q) == nm2);
    sts_o.n_one      = (n == CW'(1));
    sts_o.hit        = (krd_par_q == l_q) || ((l_q != '0) && (parl_q == h_q));
    sts_o.h_last     = (CW'(h_q) == nm1);
    sts_o.l_last     = (CW'(l_q) == nm2);
    sts_o.out_free   = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_low_o    = out_low_q;
  assign out_high_o   = out_high_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

/* rtl/core/max_spanning_tree_half_matrix.sv */
// Top level of the maximum spanning tree block over a half-matrix score store.
// Depends on msthm_pkg, msthm_ctrl and msthm_dp.
//
// Usage. Items enter on the s_axis channel. tuser selects the operation:
// store writes one pair score, build grows the maximum-weight spanning tree
// over the stored pairs among the first item_count items. A store gives no
// result, unless its index pair is bad, in which case one result with status
// "bad index pair" comes out on the next cycle. A build first grows the tree
// (an init step, then per round a read and a write step per item for the key
// update, a read and a compare step per item for the selection, and a step to
// add the chosen item), then runs the sorted edge scan; the shared key memory
// port sets these steps. Tree edges leave on m_axis as (lower, higher) pairs
// in ascending order with tlast on the final edge; if the pairs do not span
// all items, one result with status "no spanning tree" is given instead. The
// cfg channel writes item_count and is always ready. After reset the block
// clears the pair valid marks of all MAX_ITEMS*(MAX_ITEMS-1)/2 entries (496
// by default), one entry per cycle, and accepts no item meanwhile. The result
// register holds while m_axis_tready is low, and the sequencer waits while the
// register is held before it loads another result.
module max_spanning_tree_half_matrix #(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned SCORE_BITS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: pair row[4:0], pair col[9:5], pair_score_in[41:10].
  input  logic [msthm_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // Fields from bit 0: low_end[4:0], high_end[9:5].
  output logic [msthm_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [msthm_pkg::STATUS_BITS-1:0]       m_axis_tuser,
  output logic                                    m_axis_tlast,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [msthm_pkg::CNT_BITS-1:0]          cfg_data_i
);
  import msthm_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  logic [IDX_BITS-1:0] out_low, out_high;
  status_e out_status;

  // Configuration is taken in any cycle.
  assign cfg_ready_o = 1'b1;

  msthm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  msthm_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (s_axis_tuser),
    .row_i        (s_axis_tdata[4:0]),
    .col_i        (s_axis_tdata[9:5]),
    .score_i      (s_axis_tdata[41:10]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_low_o    (out_low),
    .out_high_o   (out_high),
    .out_last_o   (m_axis_tlast),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'd0, out_high, out_low};
  assign m_axis_tuser = out_status;

endmodule

/* rtl/core/msthm_chk.sv */
// Port-level checker of the maximum spanning tree block and its bind.
// Depends on the top level's port list and the status codes of msthm_pkg.
module msthm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import msthm_pkg::*;

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only the three status codes appear.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_BAD_PAIR) ||
                      (m_axis_tuser == ST_NO_TREE))
    else $error("undefined status code");

  // An error result is a single, empty, final result.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast && m_axis_tdata == 16'd0)
    else $error("malformed error result");

  // A tree edge always names the lower item first.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |-> m_axis_tdata[4:0] < m_axis_tdata[9:5])
    else $error("edge ends out of order");

endmodule

bind max_spanning_tree_half_matrix msthm_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/msthm_checker.sv */
// Result checker for the maximum spanning tree block: it watches the cfg,
// s_axis and m_axis channels, predicts results and compares. Uses msthm_pkg.
module msthm_checker #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [msthm_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [msthm_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic [msthm_pkg::STATUS_BITS-1:0]   m_axis_tuser,
  input  logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_o,
  input  logic [msthm_pkg::CNT_BITS-1:0]      cfg_data_i,
  output int                                  pending_o,
  output int                                  errors_o,
  output int                                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import msthm_pkg::*;

  localparam int TRI = MAX_ITEMS * (MAX_ITEMS - 1) / 2;

  typedef struct packed {
    logic [IDX_BITS-1:0] low_end;
    logic [IDX_BITS-1:0] high_end;
    logic                last;
    status_e             status;
  } edge_rec_t;

  edge_rec_t          tree_q[$];
  logic [CNT_BITS-1:0] count_reg = CNT_RESET;
  logic               slot_ok[TRI];
  logic signed [31:0] slot_score[TRI];
  int                 parent[MAX_ITEMS];
  logic               chosen[TRI];

  initial begin
    for (int t = 0; t < TRI; t++) slot_ok[t] = 1'b0;
  end

  function automatic int used_items();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_ITEMS) return MAX_ITEMS;
    return int'(count_reg);
  endfunction

  function automatic int root_of(int v);
    while (parent[v] != v) v = parent[v];
    return v;
  endfunction

  function automatic void push_rec(int lo, int hi, logic lst, status_e st);
    edge_rec_t e;
    e.low_end  = lo[IDX_BITS-1:0];
    e.high_end = hi[IDX_BITS-1:0];
    e.last     = lst;
    e.status   = st;
    tree_q = {tree_q, e};
  endfunction

  // Kruskal over the valid slots: highest score first, lowest slot on a tie.
  function automatic void predict_tree();
    int n, k, br, bc, bt, t, tmp;
    logic found;
    logic signed [31:0] bs;
    int lows[MAX_ITEMS];
    int highs[MAX_ITEMS];
    n = used_items();
    k = 0;
    for (int i = 0; i < MAX_ITEMS; i++) parent[i] = i;
    for (int i = 0; i < TRI; i++) chosen[i] = 1'b0;
    for (int round = 0; round + 1 < n; round++) begin
      found = 1'b0;
      bs = 0; br = 0; bc = 0; bt = 0;
      for (int r = 1; r < n; r++) begin
        for (int c = 0; c < r; c++) begin
          t = r * (r - 1) / 2 + c;
          if (!slot_ok[t] || chosen[t]) continue;
          if (root_of(r) == root_of(c)) continue;
          if (!found || slot_score[t] > bs) begin
            found = 1'b1;
            bs = slot_score[t];
            br = r; bc = c; bt = t;
          end
        end
      end
      if (!found) break;
      chosen[bt] = 1'b1;
      parent[root_of(br)] = root_of(bc);
      lows[k] = bc;
      highs[k] = br;
      k++;
    end
    if (k + 1 != n) begin
      push_rec(0, 0, 1'b1, ST_NO_TREE);
      return;
    end
    // Edges leave sorted by lower end, then by higher end.
    for (int i = 0; i < k; i++) begin
      for (int j = i + 1; j < k; j++) begin
        if (lows[j] < lows[i] || (lows[j] == lows[i] && highs[j] < highs[i])) begin
          tmp = lows[i];  lows[i]  = lows[j];  lows[j]  = tmp;
          tmp = highs[i]; highs[i] = highs[j]; highs[j] = tmp;
        end
      end
    end
    for (int i = 0; i < k; i++) push_rec(lows[i], highs[i], i + 1 == k, ST_OK);
  endfunction

  always @(posedge clk_i) begin
    int row, col, n;
    edge_rec_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        n = used_items();
        if (s_axis_tuser == MODE_BUILD) begin
          predict_tree();
        end else begin
          row = int'(s_axis_tdata[4:0]);
          col = int'(s_axis_tdata[9:5]);
          if (row <= col || row >= n || col >= n) begin
            push_rec(0, 0, 1'b1, ST_BAD_PAIR);
          end else begin
            slot_ok[row * (row - 1) / 2 + col] = 1'b1;
            slot_score[row * (row - 1) / 2 + col] = s_axis_tdata[41:10];
          end
        end
      end
      // The count register takes effect for items after this edge.
      if (cfg_valid_i && cfg_ready_o) count_reg = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (tree_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("ERROR: unexpected result low=%0d high=%0d last=%0b status=%0d",
                     m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tlast, m_axis_tuser);
        end else begin
          want = tree_q.pop_front();
          if (m_axis_tdata[4:0] !== want.low_end || m_axis_tdata[9:5] !== want.high_end ||
              m_axis_tlast !== want.last || m_axis_tuser !== want.status) begin
            errors_o++;
            if (errors_o <= 10)
              $display("ERROR: expected low=%0d high=%0d last=%0b status=%0d, got %0d %0d %0b %0d",
                       want.low_end, want.high_end, want.last, want.status,
                       m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tlast, m_axis_tuser);
          end
        end
      end
      pending_o = tree_q.size();
    end
  end

endmodule

/* tb/max_spanning_tree_half_matrix_tb.sv */
// Top of the maximum spanning tree testbench: clock, reset, stimulus and verdict.
// Depends on msthm_pkg, the block max_spanning_tree_half_matrix and msthm_checker.
module max_spanning_tree_half_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msthm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // After the last result, a short build or a store may still be running.
  localparam int SETTLE = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = MODE_STORE;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [STATUS_BITS-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CNT_BITS-1:0] cfg_data_i = '0;

  int pending, errors, checked;
  int cycles = 0;
  int burst_left = 0;
  int n_stores = 0;
  int n_builds = 0;
  int n_phases = 0;

  always #1 clk_i = ~clk_i;

  max_spanning_tree_half_matrix u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  msthm_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .pending_o(pending), .errors_o(errors), .checked_o(checked)
  );

  // Watchdog. A run that hangs anywhere ends here as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("max_spanning_tree_half_matrix verification failed");
      $finish;
    end
  end

  // The receiver switches between always ready, a random half-duty stall and
  // a heavy stall, so that back-pressure falls on every stage of the emit scan.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(120, 10);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(1);
      default: m_axis_tready <= ($urandom_range(3) == 0);
    endcase
  end

  // Offers one item and holds it until the block takes it. Every call starts
  // and ends just after a rising edge. The valid stays high inside a burst;
  // at the end of a burst it drops for a random gap before the next item.
  task automatic send_item(input logic md, input logic [4:0] row, input logic [4:0] col,
                           input logic [31:0] score);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= {6'd0, score, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (md == MODE_BUILD) n_builds++;
    else n_stores++;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 15) : $urandom_range(8);
    end else begin
      burst_left--;
    end
  endtask

  // Waits for every expected result, then for the block to finish any work
  // that gives no result, before the count register may change.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CNT_BITS-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_phases++;
  endtask

  // Scores lean toward a few shared values so that ties are common, with the
  // two extremes of the signed range now and then.
  function automatic logic [31:0] pick_score();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(3) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic int eff_items(input int value);
    if (value == 0) return 1;
    if (value > 32) return 32;
    return value;
  endfunction

  int counts[10] = '{2, 3, 5, 8, 0, 13, 32, 4, 63, 20};

  initial begin
    int n, r, c, p;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. At reset all 32 items are in use.
    send_item(MODE_STORE, 5'd7, 5'd7, 32'd1);          // row equal to col
    send_item(MODE_STORE, 5'd3, 5'd9, 32'd1);          // row below col
    send_item(MODE_STORE, 5'd31, 5'd31, 32'hFFFF_FFFF);
    send_item(MODE_STORE, 5'd31, 5'd30, 32'h7FFF_FFFF);
    send_item(MODE_STORE, 5'd31, 5'd0, 32'h8000_0000);
    send_item(MODE_BUILD, 5'd31, 5'd31, 32'hFFFF_FFFF); // no spanning tree
    write_count(6'd1);
    send_item(MODE_BUILD, 5'd0, 5'd0, 32'd0);           // single item: empty tree
    send_item(MODE_STORE, 5'd1, 5'd0, 32'd5);           // index beyond the count
    write_count(6'd2);
    send_item(MODE_STORE, 5'd1, 5'd0, 32'h7FFF_FFFF);
    send_item(MODE_BUILD, 5'd0, 5'd0, 32'd0);
    send_item(MODE_STORE, 5'd1, 5'd0, 32'h8000_0000);
    send_item(MODE_BUILD, 5'd0, 5'd0, 32'd0);
    write_count(6'd3);
    // Equal scores everywhere: the lowest slots win.
    send_item(MODE_STORE, 5'd1, 5'd0, 32'h0001_0000);
    send_item(MODE_STORE, 5'd2, 5'd0, 32'h0001_0000);
    send_item(MODE_STORE, 5'd2, 5'd1, 32'h0001_0000);
    send_item(MODE_BUILD, 5'd0, 5'd0, 32'd0);
    send_item(MODE_STORE, 5'd2, 5'd1, 32'h0002_0000);
    send_item(MODE_BUILD, 5'd0, 5'd0, 32'd0);

    // Random phases: each lays a random spanning tree with random scores,
    // adds random stores, noise and builds, then builds once more. Pairs from
    // earlier phases stay in the store and go stale when the count shrinks.
    foreach (counts[i]) begin
      write_count(counts[i][CNT_BITS-1:0]);
      n = eff_items(counts[i]);
      for (int k = 1; k < n; k++)
        send_item(MODE_STORE, k[4:0], 5'($urandom_range(k - 1)), pick_score());
      repeat (10) begin
        p = $urandom_range(99);
        if (p < 8) begin
          send_item(MODE_BUILD, 5'($urandom), 5'($urandom), $urandom);
        end else if (p < 20 || n < 2) begin
          send_item(MODE_STORE, 5'($urandom), 5'($urandom), $urandom);
        end else begin
          r = $urandom_range(n - 1, 1);
          c = $urandom_range(r - 1);
          send_item(MODE_STORE, r[4:0], c[4:0], pick_score());
        end
      end
      send_item(MODE_BUILD, 5'($urandom), 5'($urandom), $urandom);
    end

    drain();
    $display("Covered %0d stores and %0d builds over %0d count settings,", n_stores, n_builds,
             n_phases);
    $display("with %0d results compared under random back-pressure.", checked);
    if (errors == 0) begin
      $display("max_spanning_tree_half_matrix verification clean");
    end else begin
      $display("max_spanning_tree_half_matrix verification failed");
    end
    $finish;
  end

endmodule
